FILE: sv/keyed_priority_queue_macros.svh
// Assertion macros for the keyed priority queue RTL.
`ifndef KEYED_PRIORITY_QUEUE_MACROS_SVH
`define KEYED_PRIORITY_QUEUE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define KPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keyed priority queue: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define KPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keyed priority queue: next-cycle check failed");

`endif

FILE: sv/kpq_pkg.sv
// Types and codes shared by the keyed priority queue modules.
package kpq_pkg;

    // Operation codes of an input transaction
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_POP    = 3'd1;
    localparam logic [2:0] OP_PEEK   = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_UPDATE = 3'd4;
    localparam logic [2:0] OP_DUMP   = 3'd5;

    // Cell command modes
    localparam logic [2:0] CM_HOLD   = 3'd0;
    localparam logic [2:0] CM_INSERT = 3'd1;
    localparam logic [2:0] CM_DELETE = 3'd2;
    localparam logic [2:0] CM_ROTATE = 3'd3;
    localparam logic [2:0] CM_SETPRI = 3'd4;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] patient_id;
        logic [31:0] admit_time;
        logic [7:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_id;
        logic [7:0]  out_priority;
        logic [31:0] out_time;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  pri;
        logic [31:0] tm;
    } t_entry;

    // Broadcast command to every cell of the chain
    typedef struct packed {
        logic [2:0] mode;
        logic       del_head;
        t_entry     ent;
    } t_cell_cmd;

endpackage

FILE: sv/kpq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module kpq_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kpq_pkg::t_cell_cmd           i_cmd,
    input  logic [$clog2(DEPTH)-1:0]     i_bound,
    input  logic [$clog2(DEPTH+1)-1:0]   i_count,
    input  kpq_pkg::t_entry              i_prev_ent,
    input  logic                         i_prev_ahead,
    input  logic                         i_prev_seen,
    input  kpq_pkg::t_entry              i_next_ent,
    input  logic                         i_next_valid,
    input  kpq_pkg::t_entry              i_head_ent,
    output kpq_pkg::t_entry              o_ent,
    output logic                         o_valid,
    output logic                         o_ahead,
    output logic                         o_seen
);
    import kpq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_entry r_ent;
    t_entry n_ent;
    logic   r_valid;
    logic   n_valid;
    logic   w_below;
    logic   w_in_range;
    logic   w_match;

    // Compare against the entry being placed; only slots above the bound count
    assign w_below    = IW'(IDX) < i_bound;
    assign w_in_range = IW'(IDX) <= i_bound;
    assign o_ahead    = w_below &&
                        ((r_ent.pri > i_cmd.ent.pri) ||
                         ((r_ent.pri == i_cmd.ent.pri) && (r_ent.tm < i_cmd.ent.tm)));

    // Track the first key match along the chain
    assign w_match = r_valid && (r_ent.id == i_cmd.ent.id) && (r_ent.tm == i_cmd.ent.tm);
    assign o_seen  = i_prev_seen || w_match;

    always_comb begin
        n_ent   = r_ent;
        n_valid = r_valid;
        case (i_cmd.mode)
            CM_INSERT: begin
                // Keep if ahead, take the new entry at the gap, else shift down
                if (w_in_range && !o_ahead) begin
                    n_ent = i_prev_ahead ? i_cmd.ent : i_prev_ent;
                end
                if (w_in_range) begin
                    n_valid = 1'b1;
                end
            end
            CM_DELETE: begin
                // Close the gap behind the deleted slot
                if (o_seen) begin
                    n_ent   = i_next_ent;
                    n_valid = i_next_valid;
                end
            end
            CM_ROTATE: begin
                // Advance toward the head; the tail wraps the head around
                if (CW'(IDX + 1) == i_count) begin
                    n_ent = i_head_ent;
                end else if (CW'(IDX + 1) < i_count) begin
                    n_ent = i_next_ent;
                end
            end
            CM_SETPRI: begin
                if (w_match && !i_prev_seen) begin
                    n_ent.pri = i_cmd.ent.pri;
                end
            end
            default: begin
            end
        endcase
    end

    // Hold payload without reset; clear occupancy on reset
    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ent   = r_ent;
    assign o_valid = r_valid;

endmodule

FILE: sv/keyed_priority_queue.sv
// Keyed priority queue built as a chain of sorted slot cells.
//
// Input channel (i_in_valid / o_in_ready, payload i_in_item) carries one op per
// transaction: insert, pop, peek, remove by (id, time), update priority, dump.
// Output channel (o_out_valid / i_out_ready, payload o_out_item) returns the
// entries that pop, peek and dump emit; last marks the final one of an op.
// Insert, pop, peek and remove finish in the accepting cycle: all cells compare
// in parallel and shift one place, so such ops can follow every cycle while the
// output register is free. A pop or peek result appears in the cycle after accept.
// Update first sets the priority, then takes one insertion-sort step per
// remaining entry through the same chain.
// Dump first accepts, then the chain rotates by one slot per emitted entry,
// holding while the output stalls, and comes back to its original order.
// When the receiver stalls, the output register holds and no new op is taken.
// Reset empties the queue at once; slot payloads need no clearing.
module keyed_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  kpq_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output kpq_pkg::t_out_item  o_out_item
);
    import kpq_pkg::*;

    `include "keyed_priority_queue_macros.svh"

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_REBUILD = 2'd1;
    localparam logic [1:0] ST_DUMP    = 2'd2;

    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [IW-1:0] r_m;
    logic [IW-1:0] n_m;
    logic [IW-1:0] r_dcnt;
    logic [IW-1:0] n_dcnt;
    logic          r_out_valid;
    logic          n_out_valid;
    t_out_item     r_out;
    t_out_item     n_out;

    t_cell_cmd      w_cmd;
    logic [IW-1:0]  w_bound;
    logic           w_accept;
    logic           w_out_free;
    logic           w_found;
    logic           w_dump_last;
    t_entry         w_ent [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_ahead;
    logic [DEPTH-1:0] w_seen;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_found    = w_seen[DEPTH-1];
    assign w_dump_last = (CW'(r_dcnt) + CW'(1)) == r_count;

    // Build the chain of cells
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        t_entry w_prev_ent;
        logic   w_prev_ahead;
        logic   w_prev_seen;
        t_entry w_next_ent;
        logic   w_next_valid;

        if (k == 0) begin : g_first
            assign w_prev_ent   = w_cmd.ent;
            assign w_prev_ahead = 1'b1;
            assign w_prev_seen  = w_cmd.del_head;
        end else begin : g_mid
            assign w_prev_ent   = w_ent[k-1];
            assign w_prev_ahead = w_ahead[k-1];
            assign w_prev_seen  = w_seen[k-1];
        end

        if (k == DEPTH-1) begin : g_last
            assign w_next_ent   = w_ent[0];
            assign w_next_valid = 1'b0;
        end else begin : g_inner
            assign w_next_ent   = w_ent[k+1];
            assign w_next_valid = w_valid[k+1];
        end

        kpq_cell #(
            .DEPTH (DEPTH),
            .IDX   (k)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_bound      (w_bound),
            .i_count      (r_count),
            .i_prev_ent   (w_prev_ent),
            .i_prev_ahead (w_prev_ahead),
            .i_prev_seen  (w_prev_seen),
            .i_next_ent   (w_next_ent),
            .i_next_valid (w_next_valid),
            .i_head_ent   (w_ent[0]),
            .o_ent        (w_ent[k]),
            .o_valid      (w_valid[k]),
            .o_ahead      (w_ahead[k]),
            .o_seen       (w_seen[k])
        );
    end

    // Sequence operations and drive the cell command
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_m         = r_m;
        n_dcnt      = r_dcnt;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        w_cmd.mode     = CM_HOLD;
        w_cmd.del_head = 1'b0;
        w_cmd.ent.id   = i_in_item.patient_id;
        w_cmd.ent.pri  = i_in_item.priority_req;
        w_cmd.ent.tm   = i_in_item.admit_time;
        w_bound        = r_count[IW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in_item.op)
                        OP_INSERT: begin
                            // Drop the transaction when the queue is full
                            if (r_count < CW'(DEPTH)) begin
                                w_cmd.mode = CM_INSERT;
                                n_count    = r_count + CW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_count != '0) begin
                                w_cmd.mode           = CM_DELETE;
                                w_cmd.del_head       = 1'b1;
                                n_count              = r_count - CW'(1);
                                n_out_valid          = 1'b1;
                                n_out.out_id         = w_ent[0].id;
                                n_out.out_priority   = w_ent[0].pri;
                                n_out.out_time       = w_ent[0].tm;
                                n_out.last           = 1'b1;
                            end
                        end
                        OP_PEEK: begin
                            if (r_count != '0) begin
                                n_out_valid          = 1'b1;
                                n_out.out_id         = w_ent[0].id;
                                n_out.out_priority   = w_ent[0].pri;
                                n_out.out_time       = w_ent[0].tm;
                                n_out.last           = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            w_cmd.mode = CM_DELETE;
                            if (w_found) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_UPDATE: begin
                            // Set the new priority, then re-sort the chain in place
                            w_cmd.mode = CM_SETPRI;
                            if (w_found && (r_count > CW'(1))) begin
                                n_state = ST_REBUILD;
                                n_m     = IW'(1);
                            end
                        end
                        OP_DUMP: begin
                            if (r_count != '0) begin
                                n_state = ST_DUMP;
                                n_dcnt  = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REBUILD: begin
                // Insert the first unsorted slot into the sorted prefix above it
                w_cmd.mode = CM_INSERT;
                w_cmd.ent  = w_ent[r_m];
                w_bound    = r_m;
                n_m        = r_m + IW'(1);
                if ((CW'(r_m) + CW'(1)) == r_count) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DUMP: begin
                // Emit the head and rotate it to the tail
                if (w_out_free) begin
                    w_cmd.mode         = CM_ROTATE;
                    n_out_valid        = 1'b1;
                    n_out.out_id       = w_ent[0].id;
                    n_out.out_priority = w_ent[0].pri;
                    n_out.out_time     = w_ent[0].tm;
                    n_out.last         = w_dump_last;
                    n_dcnt             = r_dcnt + IW'(1);
                    if (w_dump_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance control state and the output register
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_m    <= n_m;
        r_dcnt <= n_dcnt;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Occupancy bits must add up to the queue count; count and state checks follow
    `KPQ_ASSERT_NOW(a_valid_count, i_clk, i_rst_n, 1'b1, $countones(w_valid) == r_count)
    `KPQ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `KPQ_ASSERT_NOW(a_busy_blocks, i_clk, i_rst_n, r_state != ST_IDLE, !o_in_ready)
    `KPQ_ASSERT_NOW(a_dump_range, i_clk, i_rst_n, r_state == ST_DUMP, CW'(r_dcnt) < r_count)
    `KPQ_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n,
        w_accept && (i_in_item.op == OP_POP) && (r_count != '0),
        (r_count == $past(r_count) - CW'(1)) && r_out_valid)

endmodule
